>>> hdl/ebd_pkg.sv
// Shared types, constants and helpers for the even block count distributor.
package ebd_pkg;

  localparam int MAX_RECEIVERS = 64;
  localparam int MAX_SENDERS   = 64;

  localparam int CNT_W     = 31;  // item counts and amounts
  localparam int IDX_W     = 6;   // sender / receiver index
  localparam int RCNT_W    = 7;   // receiver_count register
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = CNT_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_COUNT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load_in;    // input beat accepted
    logic cfg_write;  // config beat accepted
    logic step;       // produce one result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic cfg_known;    // config index names a register
    logic zero_amount;  // offered input carries no items
    logic div_done;     // quotient/remainder loaded this cycle
    logic out_free;     // output register can take a result
    logic run_last;     // result computed now ends the run
  } ctl_stat_t;

  // Receiver count as used: 0 acts as 1, values above the maximum clamp.
  function automatic logic [RCNT_W-1:0] eff_receivers(input logic [RCNT_W-1:0] r);
    logic [RCNT_W-1:0] e;
    e = r;
    if (r == '0) begin
      e = RCNT_W'(1);
    end else if (r > RCNT_W'(MAX_RECEIVERS)) begin
      e = RCNT_W'(MAX_RECEIVERS);
    end
    return e;
  endfunction

endpackage

>>> hdl/even_block_count_distributor.sv
// Top level of the even block count distributor.
// Splits total_count items among receiver_count receivers in contiguous blocks
// (total/R each, one more for the first total%R). Each input beat is the item
// count of the next sender; the block answers with one result beat per
// receiver that the count reaches, tlast on the final one and tuser set there
// if items beyond the configured total were dropped. A zero count yields no
// beat. An input is accepted while idle, and its run then loads one result beat
// into the output register whenever that register is free, for k from 1 to 64
// receivers touched; a zero count goes straight back to idle. The result run is
// paced by the single output register, which lets the next input be accepted
// while the last beat waits. A write to a known register restarts the
// distribution and runs a one-bit-per-cycle divider, during which neither
// channel is ready; writes to unknown indexes are taken and ignored.
module even_block_count_distributor
  import ebd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [30:0] sender_amount
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [5:0] sender_index, [11:6] receiver_index,
                                              // [42:12] amount
  output logic                   out_tlast,   // last_of_run
  output logic                   out_tuser,   // [0] overflow
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  ebd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ebd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_amount  (in_tdata[CNT_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hdl/ebd_div.sv
// Restoring divider, one quotient bit per cycle: total count over receiver count.
module ebd_div
  import ebd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CNT_W-1:0]  dividend,
  input  logic [RCNT_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [CNT_W-1:0]  quotient,
  output logic [RCNT_W-1:0] remainder
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  q_r, q_nxt;
  logic [RCNT_W-1:0] rem_r, rem_nxt;
  logic [RCNT_W-1:0] d_r, d_nxt;
  logic [RCNT_W:0]   shifted;
  logic [RCNT_W:0]   diff;
  logic              ge;

  assign shifted = {rem_r, q_r[CNT_W-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign ge      = shifted >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_STEPS - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[CNT_W-2:0], ge};
      rem_nxt = ge ? diff[RCNT_W-1:0] : shifted[RCNT_W-1:0];
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

>>> hdl/ebd_dp.sv
// Datapath: config registers, shares, distribution state and output register.
module ebd_dp
  import ebd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_cmd_t               cmd,
  output ctl_stat_t              stat,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data,
  input  logic [CNT_W-1:0]       in_amount,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0]  base_p1_r, base_p1_nxt;
  logic [IDX_W-1:0]  extra_r, extra_nxt;
  logic [IDX_W-1:0]  next_snd_r, next_snd_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  amt_r, amt_nxt;
  logic [IDX_W-1:0]  snd_r, snd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  o_snd_r, o_snd_nxt;
  logic [IDX_W-1:0]  o_rcv_r, o_rcv_nxt;
  logic [CNT_W-1:0]  o_amt_r, o_amt_nxt;
  logic              o_last_r, o_last_nxt;
  logic              o_ovf_r, o_ovf_nxt;

  logic              div_start, div_busy, div_done;
  logic [CNT_W-1:0]  div_q;
  logic [RCNT_W-1:0] div_rem;
  logic [CNT_W-1:0]  new_total;
  logic [RCNT_W-1:0] new_rcnt;

  logic [RCNT_W-1:0] reff;
  logic [CNT_W:0]    diff_ar;
  logic [CNT_W-1:0]  diff_ra;
  logic              lt;
  logic [CNT_W-1:0]  take, a_left, rem_sub, rem_new;
  logic [RCNT_W-1:0] cur_inc;
  logic              adv, last, ovf;

  assign stat.cfg_known   = (cfg_index == REG_TOTAL_COUNT) ||
                            (cfg_index == REG_RECEIVER_COUNT);
  assign stat.zero_amount = (in_amount == '0);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid_r || out_tready;
  assign stat.run_last    = last;

  assign new_total = (cfg_index == REG_TOTAL_COUNT) ? cfg_data : total_r;
  assign new_rcnt  = (cfg_index == REG_RECEIVER_COUNT) ? cfg_data[RCNT_W-1:0] : rcnt_r;
  assign div_start = cmd.cfg_write && stat.cfg_known;

  ebd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (new_total),
    .divisor   (eff_receivers(new_rcnt)),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // One piece of the run: fill the current receiver as far as the items go.
  assign reff    = eff_receivers(rcnt_r);
  assign diff_ar = {1'b0, amt_r} - {1'b0, rem_r};
  assign diff_ra = rem_r - amt_r;
  assign lt      = diff_ar[CNT_W];
  assign take    = lt ? amt_r : rem_r;
  assign a_left  = lt ? '0 : diff_ar[CNT_W-1:0];
  assign rem_sub = lt ? diff_ra : '0;
  assign cur_inc = {1'b0, cur_r} + RCNT_W'(1);
  // advance only when this piece actually emptied a nonzero quota
  assign adv     = (rem_r != '0) && (rem_sub == '0) && (cur_inc < reff);
  assign rem_new = adv ? ((cur_inc < {1'b0, extra_r}) ? base_p1_r : base_r) : rem_sub;
  assign last    = (a_left == '0) || (rem_new == '0);
  assign ovf     = last && (a_left != '0);

  always_comb begin
    total_nxt     = total_r;
    rcnt_nxt      = rcnt_r;
    base_nxt      = base_r;
    base_p1_nxt   = base_p1_r;
    extra_nxt     = extra_r;
    next_snd_nxt  = next_snd_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    amt_nxt       = amt_r;
    snd_nxt       = snd_r;
    out_valid_nxt = out_valid_r;
    o_snd_nxt     = o_snd_r;
    o_rcv_nxt     = o_rcv_r;
    o_amt_nxt     = o_amt_r;
    o_last_nxt    = o_last_r;
    o_ovf_nxt     = o_ovf_r;

    if (div_start) begin
      total_nxt = new_total;
      rcnt_nxt  = new_rcnt;
    end

    if (div_done) begin
      base_nxt     = div_q;
      base_p1_nxt  = div_q + CNT_W'(1);
      extra_nxt    = div_rem[IDX_W-1:0];
      next_snd_nxt = '0;
      cur_nxt      = '0;
      rem_nxt      = (div_rem != '0) ? div_q + CNT_W'(1) : div_q;
    end

    if (cmd.load_in) begin
      amt_nxt      = in_amount;
      snd_nxt      = next_snd_r;
      next_snd_nxt = (next_snd_r == IDX_W'(MAX_SENDERS - 1)) ? '0 : next_snd_r + IDX_W'(1);
    end

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.step) begin
      out_valid_nxt = 1'b1;
      o_snd_nxt     = snd_r;
      o_rcv_nxt     = cur_r;
      o_amt_nxt     = take;
      o_last_nxt    = last;
      o_ovf_nxt     = ovf;
      amt_nxt       = a_left;
      rem_nxt       = rem_new;
      cur_nxt       = adv ? cur_inc[IDX_W-1:0] : cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      rcnt_r      <= RCNT_W'(1);
      base_r      <= '0;
      base_p1_r   <= CNT_W'(1);
      extra_r     <= '0;
      next_snd_r  <= '0;
      cur_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      rcnt_r      <= rcnt_nxt;
      base_r      <= base_nxt;
      base_p1_r   <= base_p1_nxt;
      extra_r     <= extra_nxt;
      next_snd_r  <= next_snd_nxt;
      cur_r       <= cur_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_r    <= amt_nxt;
    snd_r    <= snd_nxt;
    o_snd_r  <= o_snd_nxt;
    o_rcv_r  <= o_rcv_nxt;
    o_amt_r  <= o_amt_nxt;
    o_last_r <= o_last_nxt;
    o_ovf_r  <= o_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CNT_W - 2 * IDX_W){1'b0}}, o_amt_r, o_rcv_r, o_snd_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_ovf_r;

`ifndef ASSERT_OFF
  a_step_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!out_valid_r || out_tready))
    else $error("result loaded over an unread beat");

  a_no_step_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !div_busy)
    else $error("result produced while shares are being recomputed");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |=> (cur_r == '0) && (next_snd_r == '0))
    else $error("distribution not restarted after config");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !last) |=> (amt_r != '0) && (rem_r != '0))
    else $error("run continues with nothing left to place");
`endif

endmodule

>>> hdl/ebd_ctrl.sv
// Controller: sequences config recompute, input accept and result run.
module ebd_ctrl
  import ebd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cfg_ready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_tready = !cfg_valid;  // config beat wins a tie
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          if (stat.cfg_known) begin
            state_nxt = ST_DIV;
          end
        end else if (in_tvalid) begin
          cmd.load_in = 1'b1;
          if (!stat.zero_amount) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.run_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> sim/tb_top.sv
// Testbench for even_block_count_distributor: directed and random beats checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
  import ebd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [CNT_W-1:0]     CNT_MAX     = '1;
  localparam logic [CNT_W-1:0]     RCNT_FILL   = 31'h7FFF_FF80;  // bits above the register
  localparam int DRAIN_CYCLES = 80;   // longest run reaches 64 receivers
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_ITEMS   = 210;

  typedef struct packed {
    logic [IDX_W-1:0] sender;
    logic [IDX_W-1:0] receiver;
    logic [CNT_W-1:0] amount;
    logic             last;
    logic             ovf;
  } grant_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CNT_W-1:0]       cfg_data = '0;

  even_block_count_distributor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  logic [CNT_W-1:0] offered_counts[$];
  grant_t           owed_grants[$];
  int               mismatches = 0;
  bit               in_fired = 1'b0;
  int               snd_idle_pct = 19;
  int               rcv_idle_pct = 76;
  int               hold_req = 0;
  int               hold_seen = 0;
  int               hold_left = 0;

  // Predictor state
  logic [CNT_W-1:0]  p_total;
  logic [RCNT_W-1:0] p_rcv_reg;
  logic [IDX_W-1:0]  p_next_sender;
  logic [RCNT_W-1:0] p_cur_rcv;
  logic [CNT_W-1:0]  p_remaining;
  logic [CNT_W-1:0]  p_base;
  logic [RCNT_W-1:0] p_extra;

  function automatic int active_receivers();
    if (p_rcv_reg == '0) begin
      return 1;
    end
    if (p_rcv_reg > RCNT_W'(MAX_RECEIVERS)) begin
      return MAX_RECEIVERS;
    end
    return int'(p_rcv_reg);
  endfunction

  function automatic logic [CNT_W-1:0] quota_for(logic [RCNT_W-1:0] idx);
    return p_base + ((idx < p_extra) ? CNT_W'(1) : CNT_W'(0));
  endfunction

  task automatic restart_split();
    int r;
    r = active_receivers();
    p_base = p_total / CNT_W'(r);
    p_extra = RCNT_W'(p_total % CNT_W'(r));
    p_next_sender = '0;
    p_cur_rcv = '0;
    p_remaining = quota_for('0);
  endtask

  task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    if (idx == REG_TOTAL_COUNT) begin
      p_total = data;
    end else if (idx == REG_RECEIVER_COUNT) begin
      p_rcv_reg = data[RCNT_W-1:0];
    end else begin
      return;
    end
    restart_split();
  endtask

  // Hand one sender's items to receivers in order; queue the grants it yields.
  task automatic split_sender_count(logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] take;
    logic [IDX_W-1:0] snd;
    int               n;
    grant_t           held;
    bit               have_held;
    snd = p_next_sender;
    p_next_sender = p_next_sender + IDX_W'(1);
    if (count == '0) begin
      return;
    end
    left = count;
    n = 0;
    have_held = 1'b0;
    held = '0;
    while (left != '0 && p_remaining != '0 && n < MAX_RECEIVERS) begin
      take = (left < p_remaining) ? left : p_remaining;
      if (have_held) begin
        owed_grants.push_back(held);
      end
      held.sender = snd;
      held.receiver = p_cur_rcv[IDX_W-1:0];
      held.amount = take;
      held.last = 1'b0;
      held.ovf = 1'b0;
      have_held = 1'b1;
      n++;
      left = left - take;
      p_remaining = p_remaining - take;
      if (p_remaining == '0 && int'(p_cur_rcv) + 1 < active_receivers()) begin
        p_cur_rcv = p_cur_rcv + RCNT_W'(1);
        p_remaining = quota_for(p_cur_rcv);
      end
    end
    if (left != '0) begin
      if (!have_held) begin
        held.sender = snd;
        held.receiver = p_cur_rcv[IDX_W-1:0];
        held.amount = '0;
      end
      held.ovf = 1'b1;
    end
    held.last = 1'b1;
    owed_grants.push_back(held);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : grant_check
    grant_t want;
    in_fired = rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      p_total = '0;
      p_rcv_reg = RCNT_W'(1);
      restart_split();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
      end
      if (in_tvalid && in_tready) begin
        split_sender_count(in_tdata[CNT_W-1:0]);
      end
      if (out_tvalid && out_tready) begin
        if (owed_grants.size() == 0) begin
          $error("result beat with nothing expected: sender %0d receiver %0d amount %0d",
                 out_tdata[5:0], out_tdata[11:6], out_tdata[42:12]);
          mismatches++;
        end else begin
          want = owed_grants.pop_front();
          check_field("sender_index", want.sender, out_tdata[5:0]);
          check_field("receiver_index", want.receiver, out_tdata[11:6]);
          check_field("amount", want.amount, out_tdata[42:12]);
          check_field("last_of_run", want.last, out_tlast);
          check_field("overflow", want.ovf, out_tuser);
        end
      end
    end
  end

  // Sender: valid holds until the beat is taken
  always @(negedge clk) begin
    if (!in_tvalid || in_fired) begin
      if (offered_counts.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= IN_TDATA_W'(offered_counts.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (offered_counts.size() != 0 || in_tvalid || owed_grants.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    #8_000_000;
    $display("even_block_count_distributor test failed");
    $finish;
  end

  initial begin : stimulus
    int          rand_items;
    int          senders;
    int          pick;
    longint      total_now;
    longint      share;
    logic [CNT_W-1:0] amt;
    logic [CNT_W-1:0] rcv_val;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // nothing owed after reset: every nonzero count overflows
    offered_counts.push_back(CNT_W'(5));
    offered_counts.push_back('0);
    offered_counts.push_back(CNT_MAX);
    wait_drained();

    // quotas 34/33/33; runs span receivers, unknown writes mid-split are ignored
    write_reg(REG_TOTAL_COUNT, CNT_W'(100));
    write_reg(REG_RECEIVER_COUNT, CNT_W'(3));
    offered_counts.push_back(CNT_W'(10));
    offered_counts.push_back(CNT_W'(50));
    wait_drained();
    write_reg(REG_SPARE_2, CNT_W'($urandom));
    write_reg(REG_SPARE_3, CNT_W'($urandom));
    offered_counts.push_back('0);
    offered_counts.push_back(CNT_W'(60));
    offered_counts.push_back(CNT_W'(1));
    wait_drained();

    // receiver count 0 acts as 1, full-scale total
    write_reg(REG_TOTAL_COUNT, CNT_MAX);
    write_reg(REG_RECEIVER_COUNT, '0);
    offered_counts.push_back(CNT_MAX);
    offered_counts.push_back(CNT_W'(1));
    wait_drained();

    // count above the maximum clamps to 64; one sender fills every receiver
    write_reg(REG_RECEIVER_COUNT, RCNT_FILL | CNT_W'(127));
    write_reg(REG_TOTAL_COUNT, CNT_W'(197));
    offered_counts.push_back(CNT_W'(197));
    wait_drained();

    // fewer items than receivers: trailing receivers are owed nothing
    write_reg(REG_RECEIVER_COUNT, RCNT_FILL | CNT_W'(65));
    write_reg(REG_TOTAL_COUNT, CNT_W'(10));
    offered_counts.push_back(CNT_W'(4));
    offered_counts.push_back(CNT_W'(8));
    wait_drained();

    write_reg(REG_TOTAL_COUNT, 31'h5555_5555);
    write_reg(REG_RECEIVER_COUNT, CNT_W'(2));
    offered_counts.push_back(31'h2AAA_AAAA);
    offered_counts.push_back(31'h2AAA_AAAB);
    wait_drained();

    write_reg(REG_TOTAL_COUNT, '0);
    write_reg(REG_RECEIVER_COUNT, CNT_W'(64));
    offered_counts.push_back(CNT_W'(7));
    offered_counts.push_back('0);
    wait_drained();

    // back-pressure: output held off while multi-receiver runs keep coming
    write_reg(REG_TOTAL_COUNT, CNT_W'(6400));
    write_reg(REG_RECEIVER_COUNT, CNT_W'(64));
    hold_req++;
    repeat (20) offered_counts.push_back(CNT_W'(290));
    wait_drained();

    total_now = 6400;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items < RAND_ITEMS / 3) begin
        snd_idle_pct = 19;
        rcv_idle_pct = 76;
      end else if (rand_items < 2 * RAND_ITEMS / 3) begin
        snd_idle_pct = 76;
        rcv_idle_pct = 19;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end

      pick = $urandom_range(0, 9);
      if (pick != 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          total_now = 0;
        end else if (pick < 4) begin
          total_now = $urandom_range(0, 300);
        end else if (pick < 7) begin
          total_now = $urandom_range(301, 200000);
        end else if (pick < 9) begin
          total_now = longint'(CNT_W'($urandom));
        end else begin
          total_now = longint'(CNT_MAX);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          rcv_val = '0;
        end else if (pick == 1) begin
          rcv_val = CNT_W'($urandom_range(65, 127));
        end else if (pick == 2) begin
          rcv_val = CNT_W'(64);
        end else begin
          rcv_val = CNT_W'($urandom_range(1, 64));
        end
        rcv_val = rcv_val | (CNT_W'($urandom) & RCNT_FILL);
        if ($urandom_range(0, 1) == 1) begin
          write_reg(REG_RECEIVER_COUNT, rcv_val);
          write_reg(REG_TOTAL_COUNT, CNT_W'(total_now));
        end else begin
          write_reg(REG_TOTAL_COUNT, CNT_W'(total_now));
          if ($urandom_range(0, 3) != 0) begin
            write_reg(REG_RECEIVER_COUNT, rcv_val);
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_3 : REG_SPARE_2, CNT_W'($urandom));
        end
      end

      // a run of senders whose counts roughly add up to the total; long runs wrap the index
      senders = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 90) : $urandom_range(1, 24);
      share = total_now / senders + 1;
      for (int i = 0; i < senders; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          amt = '0;
        end else if (pick < 14) begin
          amt = CNT_W'($urandom);
        end else if (pick < 17) begin
          amt = CNT_MAX;
        end else begin
          amt = CNT_W'($urandom_range(0, (2 * share > longint'(CNT_MAX)) ?
                                          int'(CNT_MAX) : int'(2 * share)));
        end
        offered_counts.push_back(amt);
      end
      rand_items += senders;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("even_block_count_distributor test passed");
    end else begin
      $display("even_block_count_distributor test failed");
    end
    $finish;
  end

endmodule
